// ===== design/ultrasonic_echo_range_median_unit_assert.svh =====
// Assertion macros shared by the echo ranging design files.
`ifndef ULTRASONIC_ECHO_RANGE_MEDIAN_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGE_MEDIAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EUR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define EUR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/eur_pkg.sv =====
// Package: widths, constants and status codes of the echo ranging unit.
package eur_pkg;

    localparam int unsigned ECHO_W     = 16;
    localparam int unsigned RANGE_W    = 14;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned PROD_W     = ECHO_W + RANGE_W;
    localparam int unsigned Q_SHIFT    = 16;

    // mm per us in Q16, stands for 1/5.83
    localparam logic [RANGE_W-1:0] MM_PER_US_Q16 = 14'd11241;
    localparam logic [ECHO_W-1:0]  TIMEOUT_RESET = 16'd25000;
    localparam int unsigned        MIN_ECHO_US_DEF = 116;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_TIMEOUT      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

endpackage

// ===== design/eur_in_if.sv =====
// Input channel: one echo width item.
interface eur_in_if import eur_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ECHO_W-1:0] echo_width_us;

    modport source (output valid, output echo_width_us, input ready);
    modport sink   (input valid, input echo_width_us, output ready);
endinterface

// ===== design/eur_out_if.sv =====
// Output channel: one range result item.
interface eur_out_if import eur_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RANGE_W-1:0]  dist_mm;
    logic [ECHO_W-1:0]   echo_us;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output dist_mm, output echo_us, output status,
                    input ready);
    modport sink   (input valid, input dist_mm, input echo_us, input status,
                    output ready);
endinterface

// ===== design/eur_cfg_if.sv =====
// Configuration write channel for the timeout register.
interface eur_cfg_if import eur_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ECHO_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/ultrasonic_echo_range_median_unit.sv =====
// An accepted echo item is held in the input register, then moved to the result register on the output channel.
// Throughput: 1 item per cycle while results are taken; input register -> multiply/classify/median -> result register.
// The output register lets a new item enter while a finished result waits to be taken.
// Reset (synchronous, active low): channels empty, median window and counts zero,
// timeout register 25000 us.
`include "ultrasonic_echo_range_median_unit_assert.svh"

module ultrasonic_echo_range_median_unit import eur_pkg::*; #(
    parameter int unsigned MIN_ECHO_US = MIN_ECHO_US_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eur_in_if.sink    i_echo,
    eur_cfg_if.sink   i_cfg,
    eur_out_if.source o_res
);

    localparam logic [ECHO_W-1:0] MinEcho = ECHO_W'(MIN_ECHO_US);

    logic                r_timeout;
    logic [ECHO_W-1:0]   r_timeout_us;
    logic                r_s1_vld;
    logic [ECHO_W-1:0]   r_s1_w;
    logic                r_out_vld;
    logic [RANGE_W-1:0]  r_range;
    logic [ECHO_W-1:0]   r_echo;
    t_status             r_status;

    logic                advance;
    logic                take_in;
    logic                usable;
    logic                push;
    logic [PROD_W-1:0]   prod;
    logic [RANGE_W-1:0]  mm;
    logic [RANGE_W-1:0]  filt_mm;
    logic [RANGE_W-1:0]  n_range;
    t_status             n_status;

    assign advance      = !r_out_vld || o_res.ready;
    assign i_echo.ready = !r_s1_vld || advance;
    assign take_in      = i_echo.valid && i_echo.ready;
    assign i_cfg.ready  = 1'b1;

    // width of zero falls under the short-echo case as well
    assign usable = (r_s1_w != '0) && (r_s1_w >= MinEcho);
    assign push   = r_s1_vld && advance && usable;
    assign prod   = PROD_W'(r_s1_w) * PROD_W'(MM_PER_US_Q16);
    assign mm     = prod[Q_SHIFT +: RANGE_W];

    eur_median3 u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_mm    (mm),
        .o_mm    (filt_mm)
    );

    always_comb begin
        if (!usable) begin
            n_status = ST_TIMEOUT;
            n_range  = '0;
        end else begin
            n_status = (r_s1_w >= r_timeout_us) ? ST_OUT_OF_RANGE : ST_OK;
            n_range  = filt_mm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= 1'b0;
            r_timeout_us <= TIMEOUT_RESET;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_status     <= ST_TIMEOUT;
        end else begin
            r_timeout <= r_timeout ^ (i_cfg.valid && i_cfg.ready);
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout_us <= i_cfg.data;
            end
            if (i_echo.ready) begin
                r_s1_vld <= i_echo.valid;
            end
            if (advance) begin
                r_out_vld <= r_s1_vld;
            end
            if (r_s1_vld && advance) begin
                r_status <= n_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_w <= i_echo.echo_width_us;
        end
        if (r_s1_vld && advance) begin
            r_range <= n_range;
            r_echo  <= r_s1_w;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.dist_mm = r_range;
    assign o_res.echo_us = r_echo;
    assign o_res.status  = r_status;

    `EUR_ASSERT_NOW(a_noecho_zero, i_clk, i_rst_n, r_out_vld && r_echo == '0,
                    r_status == ST_TIMEOUT && r_range == '0)
    `EUR_ASSERT_NOW(a_timeout_zero, i_clk, i_rst_n, r_out_vld && r_status == ST_TIMEOUT,
                    r_range == '0)
    `EUR_ASSERT_NEXT(a_pipe_move, i_clk, i_rst_n, r_s1_vld && advance, r_out_vld)
    `EUR_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, i_cfg.valid,
                     r_timeout_us == $past(i_cfg.data) && r_timeout != $past(r_timeout))

endmodule

// ===== design/eur_median3.sv =====
// Three-sample sliding median with raw pass-through during ramp-up.
`include "ultrasonic_echo_range_median_unit_assert.svh"

module eur_median3 import eur_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [RANGE_W-1:0] i_mm,
    output logic [RANGE_W-1:0] o_mm
);

    logic [RANGE_W-1:0] r_win [3];
    logic [RANGE_W-1:0] n_win [3];
    logic [1:0]         r_pos;
    logic [1:0]         n_pos;
    logic [1:0]         r_fill;
    logic [1:0]         n_fill;
    logic [1:0]         slot;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    logic [RANGE_W-1:0] mid;

    always_comb begin
        slot   = (r_pos > 2'd2) ? 2'd0 : r_pos;
        n_win  = r_win;
        n_win[slot] = i_mm;
        n_pos  = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        n_fill = (r_fill == 2'd3) ? r_fill : r_fill + 2'd1;

        lo  = (n_win[0] < n_win[1]) ? n_win[0] : n_win[1];
        hi  = (n_win[0] < n_win[1]) ? n_win[1] : n_win[0];
        mid = (hi < n_win[2]) ? hi : n_win[2];
        mid = (mid > lo) ? mid : lo;

        o_mm = (n_fill == 2'd3) ? mid : i_mm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_fill <= 2'd0;
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (i_push) begin
            r_pos  <= n_pos;
            r_fill <= n_fill;
            r_win  <= n_win;
        end
    end

    `EUR_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos != 2'd3)
    `EUR_ASSERT_NOW(a_rampup_raw, i_clk, i_rst_n, i_push && r_fill < 2'd2, o_mm == i_mm)
    `EUR_ASSERT_NEXT(a_fill_step, i_clk, i_rst_n, i_push && r_fill != 2'd3,
                     r_fill == $past(r_fill) + 2'd1)
    `EUR_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !i_push,
                     $stable(r_fill) && $stable(r_pos))

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the echo ranging unit: random and directed widths, checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import eur_pkg::*;

    localparam int unsigned MIN_ECHO       = MIN_ECHO_US_DEF;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          RAND_PER_PHASE = 145;

    typedef struct packed {
        logic [RANGE_W-1:0] dist_mm;
        logic [ECHO_W-1:0]  echo_us;
        t_status            status;
    } echo_result_t;

    logic i_clk;
    logic i_rst_n;

    eur_in_if  echo_ch();
    eur_cfg_if cfg_ch();
    eur_out_if res_ch();

    ultrasonic_echo_range_median_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_echo  (echo_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // predictor state
    logic [ECHO_W-1:0]  timeout_reg;
    logic [RANGE_W-1:0] med_win [3];
    logic [1:0]         win_pos;
    logic [1:0]         fill_cnt;

    logic [ECHO_W-1:0] pending_widths [$];
    echo_result_t      expected_results [$];
    int                n_queued;
    int                n_done;
    int                n_fail;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic echo_result_t predict_reading(input logic [ECHO_W-1:0] w);
        echo_result_t       r;
        logic [31:0]        prod;
        logic [RANGE_W-1:0] mm;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        logic [RANGE_W-1:0] mid;
        logic [1:0]         slot;
        r.dist_mm = '0;
        r.echo_us = '0;
        r.status  = ST_TIMEOUT;
        if (w != '0) begin
            r.echo_us = w;
            if (w >= MIN_ECHO) begin
                prod = 32'(w) * 32'(MM_PER_US_Q16);
                mm   = prod[Q_SHIFT +: RANGE_W];
                slot = (win_pos > 2'd2) ? 2'd0 : win_pos;
                med_win[slot] = mm;
                win_pos = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
                if (fill_cnt < 2'd3) fill_cnt = fill_cnt + 2'd1;
                if (fill_cnt < 2'd3) begin
                    // ramp-up: raw value passes
                    r.dist_mm = mm;
                end else begin
                    lo  = (med_win[0] < med_win[1]) ? med_win[0] : med_win[1];
                    hi  = (med_win[0] < med_win[1]) ? med_win[1] : med_win[0];
                    mid = (hi < med_win[2]) ? hi : med_win[2];
                    r.dist_mm = (mid > lo) ? mid : lo;
                end
                r.status = (w >= timeout_reg) ? ST_OUT_OF_RANGE : ST_OK;
            end
        end
        return r;
    endfunction

    // half boundary-heavy widths, the other half uniform over the full field
    function automatic logic [ECHO_W-1:0] pick_width(input logic [ECHO_W-1:0] tmo);
        int v;
        case ($urandom_range(9))
            0: v = 0;
            1: v = $urandom_range(MIN_ECHO - 1, 1);
            2: v = MIN_ECHO - 1 + $urandom_range(2);
            3: begin
                v = int'(tmo) + $urandom_range(2) - 1;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            4: v = $urandom_range(1) ? 65535 : 65535 - $urandom_range(4);
            default: v = $urandom_range(65535);
        endcase
        return v[ECHO_W-1:0];
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            echo_ch.valid <= 1'b0;
        end else if (!echo_ch.valid || echo_ch.ready) begin
            if (pending_widths.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                echo_ch.valid         <= 1'b1;
                echo_ch.echo_width_us <= pending_widths.pop_front();
            end else begin
                echo_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: tracks config, predicts on accepted input, checks accepted results
    always @(posedge i_clk) begin : monitor
        echo_result_t want;
        if (!i_rst_n) begin
            timeout_reg = TIMEOUT_RESET;
            med_win[0]  = '0;
            med_win[1]  = '0;
            med_win[2]  = '0;
            win_pos     = '0;
            fill_cnt    = '0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                n_done++;
                if (expected_results.size() == 0) begin
                    n_fail++;
                    $error("result with no pending item: dist_mm %0d echo_us %0d status %0d",
                           res_ch.dist_mm, res_ch.echo_us, res_ch.status);
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.dist_mm !== want.dist_mm) begin
                        n_fail++;
                        $error("dist_mm: expected %0d, got %0d", want.dist_mm, res_ch.dist_mm);
                    end
                    if (res_ch.echo_us !== want.echo_us) begin
                        n_fail++;
                        $error("echo_us: expected %0d, got %0d", want.echo_us, res_ch.echo_us);
                    end
                    if (res_ch.status !== want.status) begin
                        n_fail++;
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) timeout_reg = cfg_ch.data;
            if (echo_ch.valid && echo_ch.ready)
                expected_results.push_back(predict_reading(echo_ch.echo_width_us));
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((echo_ch.valid && echo_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_width(input logic [ECHO_W-1:0] w);
        pending_widths.push_back(w);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_done != n_queued) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [ECHO_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // sender holds back until the block has returned everything, then reconfigures
    task automatic run_phase(input logic [ECHO_W-1:0] tmo, input int send_pct,
                             input int recv_pct);
        wait_drained();
        write_timeout(tmo);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (RAND_PER_PHASE) push_width(pick_width(tmo));
    endtask

    initial begin
        logic [ECHO_W-1:0] dir_reset_tmo [14];
        logic [ECHO_W-1:0] dir_zero_tmo [5];
        logic [ECHO_W-1:0] mid_tmo;
        dir_reset_tmo = '{16'd0, 16'd50, 16'd116, 16'd65535, 16'd1000,
                          16'd24999, 16'd25000, 16'd25001, 16'd115,
                          16'd117, 16'h5555, 16'hAAAA, 16'd1, 16'd32768};
        dir_zero_tmo  = '{16'd116, 16'd0, 16'd115, 16'd65535, 16'd300};
        i_rst_n               = 1'b0;
        echo_ch.valid         = 1'b0;
        echo_ch.echo_width_us = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = '0;
        res_ch.ready          = 1'b0;
        n_queued              = 0;
        n_done                = 0;
        n_fail                = 0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        quiet_cycles          = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset timeout, ramp-up of the median, class boundaries
        foreach (dir_reset_tmo[k]) push_width(dir_reset_tmo[k]);
        wait_drained();
        // zero timeout: everything at or above the minimum is out of range
        write_timeout('0);
        foreach (dir_zero_tmo[k]) push_width(dir_zero_tmo[k]);

        run_phase(16'd65535, 82, 0);
        run_phase(16'd1, 0, 82);
        mid_tmo = $urandom_range(40000, 200);
        run_phase(mid_tmo, 9, 9);
        run_phase(16'd116, 0, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            n_fail++;
            $error("%0d expected results never arrived", expected_results.size());
        end
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
